@@ rtl/core/vnl_pkg.sv @@
// shared constants, types and the rsqrt seed table for the vector nlerp core
package vnl_pkg;

  localparam int COMPONENT_WIDTH_DEF    = 16;
  localparam int FRACTION_BITS_DEF      = 12;
  localparam int RSQRT_NEWTON_STEPS_DEF = 2;

  // mantissa and reciprocal root are unsigned q2.30
  localparam int MANT_W = 32;
  localparam int MANT_FRAC = 30;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int EPS_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_EPSILON = 1'd1;

  localparam logic [CFG_DATA_W-1:0] NORMALIZE_MODE_RST = 16'd1;
  localparam logic [EPS_W-1:0]      LENGTH_EPSILON_RST = 16'd17;

  // per-item control that rides along the pipe
  typedef struct packed {
    logic norm;   // apply the scaling
    logic flag;   // too short, normalization skipped
  } vnl_ctl_t;

  // rsqrt seeds in q.16 indexed by the top four mantissa bits
  function automatic logic [16:0] seed_lut(input logic [3:0] idx);
    logic [16:0] s;
    case (idx)
      4'd4:    s = 17'd61788;
      4'd5:    s = 17'd55889;
      4'd6:    s = 17'd51411;
      4'd7:    s = 17'd47861;
      4'd8:    s = 17'd44957;
      4'd9:    s = 17'd42525;
      4'd10:   s = 17'd40450;
      4'd11:   s = 17'd38651;
      4'd12:   s = 17'd37073;
      4'd13:   s = 17'd35673;
      4'd14:   s = 17'd34421;
      4'd15:   s = 17'd33292;
      default: s = 17'd65536;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/vnl_if.sv @@
// valid/ready channel interfaces for input vectors and results
interface vnl_in_if #(
  parameter int CW = 16,
  parameter int FB = 12
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] start_x;
  logic [CW-1:0] start_y;
  logic [CW-1:0] start_z;
  logic [CW-1:0] end_x;
  logic [CW-1:0] end_y;
  logic [CW-1:0] end_z;
  logic [FB:0]   blend_weight;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  blend_weight, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                blend_weight, output ready);
endinterface

interface vnl_out_if #(
  parameter int CW = 16
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] result_x;
  logic [CW-1:0] result_y;
  logic [CW-1:0] result_z;
  logic          too_short;

  modport source (output valid, result_x, result_y, result_z, too_short, input ready);
  modport sink (input valid, result_x, result_y, result_z, too_short, output ready);
endinterface

@@ rtl/core/vnl_blend.sv @@
// two-stage linear blend start + (end - start) * t with rounding and saturation
module vnl_blend import vnl_pkg::*; #(
  parameter int CW = COMPONENT_WIDTH_DEF,
  parameter int FB = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][CW-1:0]   start_v,
  input  logic [2:0][CW-1:0]   end_v,
  input  logic [FB:0]          weight,
  output logic                 out_valid,
  output logic [2:0][CW-1:0]   out_v
);

  localparam int PW = CW + FB + 3;
  localparam logic [FB:0] T_ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FB - 1);
  localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

  logic                  v1_r;
  logic                  v2_r;
  logic [2:0][CW-1:0]    s1_r;
  logic signed [PW-1:0]  prod_r [3];
  logic signed [PW-1:0]  prod_nxt [3];
  logic [2:0][CW-1:0]    out_nxt;

  // stage 1: clamp weight, difference and multiply
  always_comb begin
    logic [FB:0]          t;
    logic signed [CW:0]   diff;
    t = (weight > T_ONE) ? T_ONE : weight;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({end_v[i][CW-1], end_v[i]}) - $signed({start_v[i][CW-1], start_v[i]});
      prod_nxt[i] = diff * $signed({1'b0, t});
    end
  end

  // stage 2: round half up, add start, saturate
  always_comb begin
    logic signed [PW-1:0] rs;
    logic signed [PW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      rs  = (prod_r[i] + HALF) >>> FB;
      sum = rs + {{(PW-CW){s1_r[i][CW-1]}}, s1_r[i]};
      if (sum > MAXV)      out_nxt[i] = MAXV[CW-1:0];
      else if (sum < MINV) out_nxt[i] = MINV[CW-1:0];
      else                 out_nxt[i] = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= start_v;
      for (int i = 0; i < 3; i++) prod_r[i] <= prod_nxt[i];
      out_v <= out_nxt;
    end
  end

  assign out_valid = v2_r;

endmodule

@@ rtl/core/vnl_rsqrt.sv @@
// squared length, epsilon test, mantissa normalize and pipelined newton rsqrt
module vnl_rsqrt import vnl_pkg::*; #(
  parameter int CW = COMPONENT_WIDTH_DEF,
  parameter int NS = RSQRT_NEWTON_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][CW-1:0]     in_v,
  input  logic                   normalize_mode,
  input  logic [EPS_W-1:0]       length_epsilon,
  output logic                   out_valid,
  output vnl_ctl_t               out_ctl,
  output logic [2:0][CW-1:0]     out_v,
  output logic [$clog2(2*CW)-1:0] out_ex,
  output logic [MANT_W-1:0]      out_y
);

  localparam int LW  = 2 * CW;
  localparam int EW  = $clog2(LW);
  localparam int NST = 4 + 3 * NS;
  localparam logic [MANT_W+1:0] THREE = (MANT_W + 2)'(3) << MANT_FRAC;

  // side pipe: one entry per register stage
  logic               vld_r [NST];
  vnl_ctl_t           ctl_r [NST];
  logic [2:0][CW-1:0] v_r   [NST];
  logic [EW-1:0]      ex_r  [NST];

  logic [LW-1:0]      sq_r [3];
  logic [LW-1:0]      lsq2_r;
  logic [LW-1:0]      lsq3_r;
  logic [MANT_W-1:0]  m4_r;

  logic [LW-1:0]      sq_nxt [3];
  logic [LW-1:0]      lsq_nxt;
  vnl_ctl_t           ctl_nxt;
  logic [EW-1:0]      ex_nxt;
  logic [MANT_W-1:0]  m_nxt;

  always_comb begin
    logic signed [LW-1:0] p;
    for (int i = 0; i < 3; i++) begin
      p = $signed(in_v[i]) * $signed(in_v[i]);
      sq_nxt[i] = p;
    end
  end

  always_comb begin
    logic short_len;
    lsq_nxt = sq_r[0] + sq_r[1] + sq_r[2];
    short_len = (lsq_nxt < LW'(length_epsilon)) || (lsq_nxt == '0);
    ctl_nxt.norm = normalize_mode && !short_len;
    ctl_nxt.flag = normalize_mode && short_len;
  end

  // leading one, rounded down to even
  always_comb begin
    logic [EW-1:0] tb;
    tb = '0;
    for (int b = 0; b < LW; b++) begin
      if (lsq2_r[b]) tb = EW'(b);
    end
    ex_nxt = tb & ~EW'(1);
  end

  always_comb begin
    logic [LW+MANT_FRAC-1:0] wide;
    wide  = {lsq3_r, {MANT_FRAC{1'b0}}} >> ex_r[2];
    m_nxt = wide[MANT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < NST; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= in_v;
      for (int j = 1; j < NST; j++) v_r[j] <= v_r[j-1];
      // slots ahead of the stage that produces them stay zero
      ctl_r[0] <= '0;
      ex_r[0]  <= '0;
      ex_r[1]  <= '0;
      ctl_r[1] <= ctl_nxt;
      for (int j = 2; j < NST; j++) ctl_r[j] <= ctl_r[j-1];
      ex_r[2]  <= ex_nxt;
      for (int j = 3; j < NST; j++) ex_r[j] <= ex_r[j-1];
      for (int i = 0; i < 3; i++) sq_r[i] <= sq_nxt[i];
      lsq2_r <= lsq_nxt;
      lsq3_r <= lsq2_r;
      m4_r   <= m_nxt;
    end
  end

  // newton chain: y <- y * (3 - m*y*y) / 2, three stages per step
  logic [NS:0][MANT_W-1:0]   y_chain;
  logic [NS:0][MANT_W-1:0]   m_chain;

  assign y_chain[0] = MANT_W'(seed_lut(m4_r[MANT_W-1:MANT_W-4])) << 14;
  assign m_chain[0] = m4_r;

  for (genvar k = 0; k < NS; k++) begin : g_nr
    logic [MANT_W-1:0]   a_y_r, a_m_r, a_y2_r;
    logic [MANT_W-1:0]   b_y_r, b_m_r;
    logic [MANT_W+1:0]   b_my2_r;
    logic [MANT_W-1:0]   c_y_r, c_m_r;
    logic [2*MANT_W-1:0] yy;
    logic [2*MANT_W-1:0] my;
    logic [MANT_W+1:0]   diff;
    logic [2*MANT_W-1:0] yd;

    assign yy   = y_chain[k] * y_chain[k];
    assign my   = a_m_r * a_y2_r;
    assign diff = (b_my2_r > THREE) ? '0 : THREE - b_my2_r;
    assign yd   = b_y_r * diff[MANT_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        a_y_r   <= y_chain[k];
        a_m_r   <= m_chain[k];
        a_y2_r  <= yy[MANT_FRAC +: MANT_W];
        b_y_r   <= a_y_r;
        b_m_r   <= a_m_r;
        b_my2_r <= my[MANT_FRAC +: MANT_W+2];
        c_y_r   <= yd[MANT_FRAC+1 +: MANT_W];
        c_m_r   <= b_m_r;
      end
    end

    assign y_chain[k+1] = c_y_r;
    assign m_chain[k+1] = c_m_r;
  end

  assign out_valid = vld_r[NST-1];
  assign out_ctl   = ctl_r[NST-1];
  assign out_v     = v_r[NST-1];
  assign out_ex    = ex_r[NST-1];
  assign out_y     = y_chain[NS];

endmodule

@@ rtl/core/vnl_scale.sv @@
// multiply by the reciprocal root, round by a length-dependent shift, saturate; pass through when not normalizing
module vnl_scale import vnl_pkg::*; #(
  parameter int CW = COMPONENT_WIDTH_DEF,
  parameter int FB = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  vnl_ctl_t                in_ctl,
  input  logic [2:0][CW-1:0]      in_v,
  input  logic [$clog2(2*CW)-1:0] in_ex,
  input  logic [MANT_W-1:0]       in_y,
  output logic                    out_valid,
  output logic [2:0][CW-1:0]      out_v,
  output logic                    out_flag
);

  localparam int EW  = $clog2(2 * CW);
  localparam int PPW = CW + MANT_W + 1;
  localparam int SHW = $clog2(MANT_FRAC + CW + 1);
  localparam int SH_BASE = MANT_FRAC - FB;
  localparam logic signed [PPW-1:0] MAXV = PPW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [PPW-1:0] MINV = -MAXV - PPW'(1);

  logic                  v1_r, v2_r, v3_r;
  vnl_ctl_t              c1_r, c2_r;
  logic [2:0][CW-1:0]    x1_r, x2_r;
  logic signed [PPW-1:0] p1_r [3];
  logic signed [PPW-1:0] p2_r [3];
  logic [SHW-1:0]        sh1_r, sh2_r;
  logic signed [PPW-1:0] p_nxt [3];
  logic signed [PPW-1:0] pr_nxt [3];
  logic [2:0][CW-1:0]    out_nxt;
  logic [SHW-1:0]        sh_nxt;

  always_comb begin
    sh_nxt = SHW'(SH_BASE) + SHW'(in_ex >> 1);
    for (int i = 0; i < 3; i++) begin
      p_nxt[i]  = $signed(in_v[i]) * $signed({1'b0, in_y});
      pr_nxt[i] = p1_r[i] + (PPW'(1) <<< (sh1_r - SHW'(1)));
    end
  end

  always_comb begin
    logic signed [PPW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = p2_r[i] >>> sh2_r;
      if (!c2_r.norm)   out_nxt[i] = x2_r[i];
      else if (q > MAXV) out_nxt[i] = MAXV[CW-1:0];
      else if (q < MINV) out_nxt[i] = MINV[CW-1:0];
      else               out_nxt[i] = q[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= in_ctl;
      c2_r  <= c1_r;
      x1_r  <= in_v;
      x2_r  <= x1_r;
      sh1_r <= sh_nxt;
      sh2_r <= sh1_r;
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= p_nxt[i];
        p2_r[i] <= pr_nxt[i];
      end
      out_v    <= out_nxt;
      out_flag <= c2_r.flag;
    end
  end

  assign out_valid = v3_r;

endmodule

@@ rtl/core/vec3_normalized_lerp_core.sv @@
// top level of the pipelined normalized vector blend (nlerp)
//
//  channel   dir   handshake      beat contents
//  in_ch     in    valid/ready    start_x/y/z, end_x/y/z, blend_weight
//  out_ch    out   valid/ready    result_x/y/z, too_short
//  cfg_*     in    cfg_we only    cfg_index selects register, cfg_wdata value
//
// one beat enters per cycle while the output is not stalled; the pipe runs through
// the blend, length, newton and scaling stages
// synchronous active-low reset clears valid bits and loads config register defaults
// a stalled output freezes the whole pipe in place; in_ch.ready follows
// out_ch.ready whenever the output register holds a beat
module vec3_normalized_lerp_core import vnl_pkg::*; #(
  parameter int COMPONENT_WIDTH    = COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS      = FRACTION_BITS_DEF,
  parameter int RSQRT_NEWTON_STEPS = RSQRT_NEWTON_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vnl_in_if.sink                in_ch,
  vnl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int EW = $clog2(2 * CW);

  // config registers
  logic             normalize_mode_r;
  logic [EPS_W-1:0] length_epsilon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normalize_mode_r <= NORMALIZE_MODE_RST[0];
      length_epsilon_r <= LENGTH_EPSILON_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORMALIZE_MODE: normalize_mode_r <= cfg_wdata[0];
        CFG_LENGTH_EPSILON: length_epsilon_r <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: pipe moves unless the output beat is held
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic [2:0][CW-1:0] start_v, end_v;
  assign start_v = {in_ch.start_z, in_ch.start_y, in_ch.start_x};
  assign end_v   = {in_ch.end_z, in_ch.end_y, in_ch.end_x};

  // blend stage outputs
  logic               bl_valid;
  logic [2:0][CW-1:0] bl_v;

  vnl_blend #(
    .CW (CW),
    .FB (FRACTION_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .start_v   (start_v),
    .end_v     (end_v),
    .weight    (in_ch.blend_weight),
    .out_valid (bl_valid),
    .out_v     (bl_v)
  );

  // length and reciprocal root
  logic               rs_valid;
  vnl_ctl_t           rs_ctl;
  logic [2:0][CW-1:0] rs_v;
  logic [EW-1:0]      rs_ex;
  logic [MANT_W-1:0]  rs_y;

  vnl_rsqrt #(
    .CW (CW),
    .NS (RSQRT_NEWTON_STEPS)
  ) u_rsqrt (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (bl_valid),
    .in_v           (bl_v),
    .normalize_mode (normalize_mode_r),
    .length_epsilon (length_epsilon_r),
    .out_valid      (rs_valid),
    .out_ctl        (rs_ctl),
    .out_v          (rs_v),
    .out_ex         (rs_ex),
    .out_y          (rs_y)
  );

  // final scaling; its last register is the output register
  logic [2:0][CW-1:0] res_v;

  vnl_scale #(
    .CW (CW),
    .FB (FRACTION_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rs_valid),
    .in_ctl    (rs_ctl),
    .in_v      (rs_v),
    .in_ex     (rs_ex),
    .in_y      (rs_y),
    .out_valid (out_ch.valid),
    .out_v     (res_v),
    .out_flag  (out_ch.too_short)
  );

  assign out_ch.result_x = res_v[0];
  assign out_ch.result_y = res_v[1];
  assign out_ch.result_z = res_v[2];

endmodule

@@ tb/tb_vnl_pkg.sv @@
// testbench package: scoreboard class holding the nlerp prediction and the pending results
package tb_vnl_pkg;
  import vnl_pkg::*;

  typedef struct packed {
    logic [15:0] sx, sy, sz, ex, ey, ez;
    logic [12:0] w;
  } vec_pair_t;

  typedef struct packed {
    logic [15:0] rx, ry, rz;
    logic        short_flag;
  } vec_res_t;

  class nlerp_scoreboard;
    bit          normalize_on = 1;
    logic [15:0] eps_sq       = LENGTH_EPSILON_RST;
    vec_res_t    pending[$];
    int          errors;

    static function longint rnd_shift(longint x, int n);
      longint a;
      a = x + (longint'(1) <<< (n - 1));
      return a >>> n;
    endfunction

    static function longint clamp16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    static function logic [16:0] rsqrt_seed(logic [3:0] i);
      case (i)
        4'd4: return 61788;  4'd5: return 55889;  4'd6: return 51411;
        4'd7: return 47861;  4'd8: return 44957;  4'd9: return 42525;
        4'd10: return 40450; 4'd11: return 38651; 4'd12: return 37073;
        4'd13: return 35673; 4'd14: return 34421; 4'd15: return 33292;
        default: return 65536;
      endcase
    endfunction

    function vec_res_t blend(vec_pair_t p);
      longint s[3], e[3], v[3];
      longint unsigned t, lsq, m, y, y2, my2, diff, three;
      int top, ex, sh;
      vec_res_t r;
      s = '{longint'(signed'(p.sx)), longint'(signed'(p.sy)), longint'(signed'(p.sz))};
      e = '{longint'(signed'(p.ex)), longint'(signed'(p.ey)), longint'(signed'(p.ez))};
      t = (p.w > 4096) ? 4096 : p.w;
      lsq = 0;
      r.short_flag = 0;
      for (int i = 0; i < 3; i++) begin
        v[i] = clamp16(s[i] + rnd_shift((e[i] - s[i]) * longint'(t), 12));
        lsq += longint'(v[i] * v[i]);
      end
      if (normalize_on) begin
        if (lsq < eps_sq || lsq == 0) r.short_flag = 1;
        else begin
          top = 0;
          for (int b = 0; b < 64; b++) if (lsq[b]) top = b;
          ex = top & ~1;
          m = (ex <= 30) ? (lsq << (30 - ex)) : (lsq >> (ex - 30));
          y = longint'(rsqrt_seed(m[31:28])) << 14;
          three = 64'd3 << 30;
          for (int k = 0; k < RSQRT_NEWTON_STEPS_DEF; k++) begin
            y2 = (y * y) >> 30;
            my2 = (m * y2) >> 30;
            diff = (my2 > three) ? 0 : three - my2;
            y = (y * diff) >> 31;
          end
          sh = 30 + ex / 2 - 12;
          for (int i = 0; i < 3; i++) v[i] = clamp16(rnd_shift(v[i] * longint'(y), sh));
        end
      end
      r.rx = v[0][15:0];
      r.ry = v[1][15:0];
      r.rz = v[2][15:0];
      return r;
    endfunction

    function void note_input(vec_pair_t p);
      pending.push_back(blend(p));
    endfunction

    function void check_result(vec_res_t got);
      vec_res_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.rx !== exp_r.rx) begin
        $error("result_x exp %0d got %0d", signed'(exp_r.rx), signed'(got.rx)); errors++;
      end
      if (got.ry !== exp_r.ry) begin
        $error("result_y exp %0d got %0d", signed'(exp_r.ry), signed'(got.ry)); errors++;
      end
      if (got.rz !== exp_r.rz) begin
        $error("result_z exp %0d got %0d", signed'(exp_r.rz), signed'(got.rz)); errors++;
      end
      if (got.short_flag !== exp_r.short_flag) begin
        $error("too_short exp %0b got %0b", exp_r.short_flag, got.short_flag); errors++;
      end
    endfunction
  endclass
endpackage

@@ tb/tb_vec3_normalized_lerp_core.sv @@
// top-level testbench for the vector nlerp core
module tb_vec3_normalized_lerp_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vnl_pkg::*;
  import tb_vnl_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vnl_in_if  in_ch ();
  vnl_out_if out_ch ();

  vec3_normalized_lerp_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  nlerp_scoreboard sb;
  // idle rate in percent, zero during the no-gap stretch
  int idle_pct = 10;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random backpressure, check every beat
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.result_x, out_ch.result_y, out_ch.result_z,
                         out_ch.too_short});
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // one beat, held until accepted; random gap before it
  task automatic send_beat(vec_pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y,
     in_ch.end_z, in_ch.blend_weight} <= p;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(p);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_NORMALIZE_MODE) sb.normalize_on = val[0];
    else sb.eps_sq = val;
  endtask

  // drain the pipe before touching config
  task automatic wait_idle();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_comp(int kind);
    case (kind)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(64)) - 16'd32;
      3: return 16'($urandom_range(8192)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vec_pair_t rnd_pair();
    vec_pair_t p;
    int k;
    k = $urandom_range(9);
    p.sx = rnd_comp(k < 5 ? $urandom_range(4) : 4);
    p.sy = rnd_comp(k < 5 ? $urandom_range(4) : 4);
    p.sz = rnd_comp(k < 5 ? $urandom_range(4) : 4);
    p.ex = rnd_comp(k < 5 ? $urandom_range(4) : 4);
    p.ey = rnd_comp(k < 5 ? $urandom_range(4) : 4);
    p.ez = rnd_comp(k < 5 ? $urandom_range(4) : 4);
    case ($urandom_range(5))
      0: p.w = 0;
      1: p.w = 4096;
      2: p.w = 13'($urandom);   // weights above one included
      default: p.w = 13'($urandom_range(4096));
    endcase
    return p;
  endfunction

  initial begin
    int setting;
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_NORMALIZE_MODE;
    cfg_wdata = 0;
    in_ch.valid = 0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y,
     in_ch.end_z, in_ch.blend_weight} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, weight above one, zero vector, tiny length under reset eps
    send_beat({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 13'd4096});
    send_beat({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 13'd0});
    send_beat({16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h0000, 13'd2048});
    send_beat({16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 13'h1fff});
    send_beat({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'd100});
    send_beat({16'h0002, 16'hffff, 16'h0000, 16'h0002, 16'hffff, 16'h0000, 13'd0});
    send_beat({16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'd0});
    send_beat({16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 13'd4097});
    send_beat({16'h5555, 16'haaaa, 16'h1234, 16'h0f0f, 16'hf0f0, 16'hedcb, 13'd1});
    wait_idle();
    // zero epsilon: only the zero vector is flagged
    write_reg(CFG_LENGTH_EPSILON, 16'd0);
    send_beat('0);
    send_beat({16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 13'd0});
    wait_idle();
    write_reg(CFG_NORMALIZE_MODE, 16'd0);
    send_beat({16'h8000, 16'h7fff, 16'h0003, 16'h7fff, 16'h8000, 16'h0000, 13'd3000});
    send_beat('0);
    wait_idle();

    // random phases through several settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      setting = ph;
      write_reg(CFG_NORMALIZE_MODE, (setting == 1) ? 16'd0 : 16'hfffe | 16'(setting != 4));
      case (setting)
        0: write_reg(CFG_LENGTH_EPSILON, 16'hffff);
        2: write_reg(CFG_LENGTH_EPSILON, 16'd0);
        default: write_reg(CFG_LENGTH_EPSILON, 16'($urandom));
      endcase
      idle_pct = (ph == 3) ? 0 : 10;
      for (int n = 0; n < 180; n++) send_beat(rnd_pair());
      wait_idle();
    end
    idle_pct = 10;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/vnl_pkg.sv
rtl/core/vnl_if.sv
rtl/core/vnl_blend.sv
rtl/core/vnl_rsqrt.sv
rtl/core/vnl_scale.sv
rtl/core/vec3_normalized_lerp_core.sv
tb/tb_vnl_pkg.sv
tb/tb_vec3_normalized_lerp_core.sv
